[rtl/mtac_pkg.sv]
// Shared types, register map, item codes and helpers of the motion and tamper alarm controller.
`default_nettype none

package mtac_pkg;

	// Item kinds carried in the input tuser field.
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_PRESS  = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_ACCEL_STEP = 3'd0;
	localparam logic [2:0] REG_GYRO_LIMIT = 3'd1;
	localparam logic [2:0] REG_HALL_LIMIT = 3'd2;
	localparam logic [2:0] REG_ALARM_DUR  = 3'd3;
	localparam logic [2:0] REG_DEBOUNCE   = 3'd4;

	// Register reset values.
	localparam logic [15:0] ACCEL_STEP_RST = 16'd60;
	localparam logic [14:0] GYRO_LIMIT_RST = 15'd20;
	localparam logic [14:0] HALL_LIMIT_RST = 15'd500;
	localparam logic [15:0] ALARM_DUR_RST  = 16'd1200;
	localparam logic [15:0] DEBOUNCE_RST   = 16'd250;

	localparam logic [15:0] PRESS_AGE_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] accel_step_limit;
		logic [14:0] gyro_limit;
		logic [14:0] hall_limit;
		logic [15:0] alarm_duration;
		logic [15:0] debounce_time;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [2:0][15:0] accel;
		logic [2:0][15:0] gyro;
		logic [15:0]      hall;
	} item_t;

	// Declared from the top bit down so that is_armed lands in bit 0.
	typedef struct packed {
		logic hall_flag;
		logic gyro_flag;
		logic accel_flag;
		logic siren_pulse;
		logic alarm_on;
		logic is_armed;
	} result_t;

	// Magnitude of a two's complement reading; the most negative value gives 32768.
	function automatic logic [15:0] mag16(input logic [15:0] v);
		logic [15:0] neg;
		neg = 16'(~v + 16'd1);
		return v[15] ? neg : v;
	endfunction

endpackage

`default_nettype wire

[rtl/mtac_cfg_regs.sv]
// Configuration register file of the alarm controller behind an APB-style port.
`default_nettype none

module mtac_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	output mtac_pkg::cfg_t     cfg
);

	mtac_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_step_limit <= mtac_pkg::ACCEL_STEP_RST;
			cfg_q.gyro_limit       <= mtac_pkg::GYRO_LIMIT_RST;
			cfg_q.hall_limit       <= mtac_pkg::HALL_LIMIT_RST;
			cfg_q.alarm_duration   <= mtac_pkg::ALARM_DUR_RST;
			cfg_q.debounce_time    <= mtac_pkg::DEBOUNCE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				mtac_pkg::REG_ACCEL_STEP: cfg_q.accel_step_limit <= pwdata[15:0];
				mtac_pkg::REG_GYRO_LIMIT: cfg_q.gyro_limit       <= pwdata[14:0];
				mtac_pkg::REG_HALL_LIMIT: cfg_q.hall_limit       <= pwdata[14:0];
				mtac_pkg::REG_ALARM_DUR:  cfg_q.alarm_duration   <= pwdata[15:0];
				mtac_pkg::REG_DEBOUNCE:   cfg_q.debounce_time    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mtac_pkg::REG_ACCEL_STEP: prdata = {16'd0, cfg_q.accel_step_limit};
			mtac_pkg::REG_GYRO_LIMIT: prdata = {17'd0, cfg_q.gyro_limit};
			mtac_pkg::REG_HALL_LIMIT: prdata = {17'd0, cfg_q.hall_limit};
			mtac_pkg::REG_ALARM_DUR:  prdata = {16'd0, cfg_q.alarm_duration};
			mtac_pkg::REG_DEBOUNCE:   prdata = {16'd0, cfg_q.debounce_time};
			default:                  prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/mtac_core.sv]
// Alarm state, threshold compares and next-result logic for one registered item.
`default_nettype none

module mtac_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mtac_pkg::cfg_t    cfg,
	input  wire mtac_pkg::item_t   item,
	input  wire logic              fire,
	output mtac_pkg::result_t      result
);

	logic              primed_q;
	logic [2:0][15:0]  last_accel_q;
	logic              armed_q;
	logic              alarm_q;
	logic [15:0]       alarm_left_q;
	logic [15:0]       press_age_q;

	logic              primed_d;
	logic [2:0][15:0]  last_accel_d;
	logic              armed_d;
	logic              alarm_d;
	logic [15:0]       alarm_left_d;
	logic [15:0]       press_age_d;

	logic [2:0]        accel_hit;
	logic [2:0]        gyro_hit;
	logic              hall_hit;
	logic [2:0][16:0]  accel_diff;
	logic [2:0][16:0]  accel_mag;
	logic [15:0]       alarm_left_dec;
	logic              fa, fg, fh, sound;

	// Per-axis compares; the step is taken at 17 bits so it cannot overflow.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			accel_diff[i] = 17'({item.accel[i][15], item.accel[i]}
				- {last_accel_q[i][15], last_accel_q[i]});
			accel_mag[i]  = accel_diff[i][16] ? 17'(~accel_diff[i] + 17'd1) : accel_diff[i];
			accel_hit[i]  = accel_mag[i] > {1'b0, cfg.accel_step_limit};
			gyro_hit[i]   = mtac_pkg::mag16(item.gyro[i]) > {1'b0, cfg.gyro_limit};
		end
		hall_hit = mtac_pkg::mag16(item.hall) > {1'b0, cfg.hall_limit};
	end

	assign alarm_left_dec = (alarm_left_q != 16'd0) ? 16'(alarm_left_q - 16'd1) : 16'd0;

	always_comb begin
		primed_d     = primed_q;
		last_accel_d = last_accel_q;
		armed_d      = armed_q;
		alarm_d      = alarm_q;
		alarm_left_d = alarm_left_q;
		press_age_d  = press_age_q;
		fa           = 1'b0;
		fg           = 1'b0;
		fh           = 1'b0;
		sound        = 1'b0;
		case (item.op)
			mtac_pkg::OP_SAMPLE: begin
				// The first sample after reset stores the axes with no accel step compare; gyro and hall still compare.
				fa           = primed_q && (accel_hit != 3'd0);
				fg           = gyro_hit != 3'd0;
				fh           = hall_hit;
				primed_d     = 1'b1;
				last_accel_d = item.accel;
				if (armed_q && !alarm_q && (fa || fg || fh)) begin
					alarm_d      = 1'b1;
					alarm_left_d = cfg.alarm_duration;
					sound        = 1'b1;
				end
			end
			mtac_pkg::OP_PRESS: begin
				if (press_age_q >= cfg.debounce_time) begin
					press_age_d  = 16'd0;
					armed_d      = !armed_q;
					alarm_d      = 1'b0;
					alarm_left_d = 16'd0;
				end
			end
			mtac_pkg::OP_TICK: begin
				if (press_age_q != mtac_pkg::PRESS_AGE_MAX)
					press_age_d = 16'(press_age_q + 16'd1);
				if (alarm_q) begin
					alarm_left_d = alarm_left_dec;
					if (alarm_left_dec == 16'd0)
						alarm_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q     <= 1'b0;
			last_accel_q <= '0;
			armed_q      <= 1'b0;
			alarm_q      <= 1'b0;
			alarm_left_q <= 16'd0;
			press_age_q  <= 16'd0;
		end else if (fire) begin
			primed_q     <= primed_d;
			last_accel_q <= last_accel_d;
			armed_q      <= armed_d;
			alarm_q      <= alarm_d;
			alarm_left_q <= alarm_left_d;
			press_age_q  <= press_age_d;
		end
	end

	always_comb begin
		result.is_armed    = armed_d;
		result.alarm_on    = alarm_d;
		result.siren_pulse = sound;
		result.accel_flag  = fa;
		result.gyro_flag   = fg;
		result.hall_flag   = fh;
	end

endmodule

`default_nettype wire

[rtl/motion_tamper_alarm_controller.sv]
// Top level of the motion and tamper alarm controller.
//
// Items arrive on the s_axis stream: tuser holds the kind (sample, button
// press or one-millisecond tick), tdata the seven sensor readings. Every
// item gives exactly one result on the m_axis stream: armed and alarm
// state after the item, the sound pulse and the three sample flags.
// Thresholds, alarm length and debounce time sit in five APB registers
// at byte addresses 0, 4, 8, 12 and 16; the user must write them only
// while no item is in flight, which the block itself does not enforce.
// An accepted item is held in an input register while the compares and
// the state update run, then lands in the result register once the
// receiver is not stalling it. The block takes one item per cycle while
// the receiver keeps up, limited by the single state-update step that
// each item passes through.
// When the receiver stalls, the result register holds its transfer and the
// input register fills; s_axis_tready then drops until the result moves.
// The asynchronous reset restores the register defaults, clears the alarm
// state (disarmed, unprimed) and empties both stages.
`default_nettype none

module motion_tamper_alarm_controller (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// tdata: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, hall_reading
	input  wire logic [111:0]  s_axis_tdata,
	// tuser: operation
	input  wire logic [1:0]    s_axis_tuser,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// tdata: is_armed, alarm_on, siren_pulse, accel_flag, gyro_flag, hall_flag, zero pad
	output logic      [7:0]    m_axis_tdata,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready
);

	mtac_pkg::cfg_t     cfg;
	mtac_pkg::item_t    item_s1;
	mtac_pkg::result_t  result;
	mtac_pkg::result_t  result_q;
	logic               valid_s1;
	logic               out_valid_q;
	logic               advance;
	logic               fire;

	mtac_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mtac_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (fire),
		.result (result)
	);

	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.op       <= s_axis_tuser;
			item_s1.accel[0] <= s_axis_tdata[15:0];
			item_s1.accel[1] <= s_axis_tdata[31:16];
			item_s1.accel[2] <= s_axis_tdata[47:32];
			item_s1.gyro[0]  <= s_axis_tdata[63:48];
			item_s1.gyro[1]  <= s_axis_tdata[79:64];
			item_s1.gyro[2]  <= s_axis_tdata[95:80];
			item_s1.hall     <= s_axis_tdata[111:96];
		end
		if (fire)
			result_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, result_q};

endmodule

`default_nettype wire

[rtl/mtac_checker.sv]
// Port-level checks of the alarm controller's result stream, bound to the top level.
`default_nettype none

module mtac_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata
);

	// Any clock edge seen in reset leaves the result stage empty.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result valid after a reset edge");

	// A stalled result transfer keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// The sound pulse only comes with an alarm that has just started while armed.
	a_sound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1] && m_axis_tdata[0])
		else $error("sound pulse without running armed alarm");

	// Any press that changes the armed state clears the alarm, so an alarm implies armed.
	a_alarm_armed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
		else $error("alarm running while disarmed");

endmodule

bind motion_tamper_alarm_controller mtac_checker u_mtac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
